// File: rtl/tsp2opt_pkg.sv
// Shared constants for the 2-opt tour search block.
package tsp2opt_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 20;

    // Result fields at fixed widths
    localparam int CITY_W = 6;
    localparam int LEN_W  = 27;
    localparam int OUT_W  = ((CITY_W + LEN_W + 1 + 7) / 8) * 8;

endpackage

// File: rtl/tsp2opt_ram.sv
// Generic simple dual-port RAM with registered read.
module tsp2opt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tsp2opt_dist.sv
// Rounded Euclidean distance unit: one multiplier and an iterative square root.
module tsp2opt_dist #(
    parameter int COORD_BITS = tsp2opt_pkg::DEF_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS-1:0] x2,
    input  logic signed [COORD_BITS-1:0] y2,
    output logic                         done,
    output logic [COORD_BITS:0]          dist_out
);

    localparam int DW   = COORD_BITS + 1;
    localparam int SQ_W = 2 * DW;
    localparam int IT_W = $clog2(DW + 1);

    typedef enum logic [5:0] {
        D_IDLE = 6'b000001,
        D_DIF  = 6'b000010,
        D_SQX  = 6'b000100,
        D_SQY  = 6'b001000,
        D_ROOT = 6'b010000,
        D_RND  = 6'b100000
    } dist_state_t;

    dist_state_t state_reg, state_next;

    logic signed [COORD_BITS:0] dxs, dys;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]       prod_reg, s_reg;
    logic [DW+1:0]         rem_reg, rem_sh, trial;
    logic [DW-1:0]         root_reg;
    logic [IT_W-1:0]       it_reg;
    logic                  ge;

    assign dxs = {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
    assign dys = {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};

    assign rem_sh = {rem_reg[DW-1:0], s_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_DIF;
            D_DIF:  state_next = D_SQX;
            D_SQX:  state_next = D_SQY;
            D_SQY:  state_next = D_ROOT;
            D_ROOT: if (it_reg == IT_W'(DW - 1)) state_next = D_RND;
            D_RND:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == D_RND);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    // hold absolute differences
                    dx_reg <= dxs[COORD_BITS] ? COORD_BITS'(-dxs) : COORD_BITS'(dxs);
                    dy_reg <= dys[COORD_BITS] ? COORD_BITS'(-dys) : COORD_BITS'(dys);
                end
            end
            D_DIF:
            begin
                prod_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            end
            D_SQX:
            begin
                s_reg    <= prod_reg;
                prod_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            end
            D_SQY:
            begin
                s_reg    <= s_reg + prod_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                it_reg   <= '0;
            end
            D_ROOT:
            begin
                rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[DW-2:0], ge};
                s_reg    <= s_reg << 2;
                it_reg   <= it_reg + IT_W'(1);
            end
            D_RND:
            begin
                // round half up: remainder above root means past the midpoint
                dist_out <= (rem_reg > (DW + 2)'(root_reg)) ? root_reg + DW'(1) : root_reg;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/tsp_two_opt_search.sv
// Top level: point loader, distance table, 2-opt search sequencer and tour output.
//
//  channel | signals                        | contents (low bit first)
//  in      | s_tvalid s_tready s_tdata s_tlast | x_coord, y_coord; tlast = last_point
//  out     | m_tvalid m_tready m_tdata m_tlast | city_index, total_length; tlast = last_city
//
//  Loading point p runs one square root of COORD_BITS+1 steps per stored point, two
//  table writes each. After the last point the 2-opt search runs states T_RA to T_CMP
//  per trial and R_RA, R_RB, R_WA, R_WB per swapped pair of a reversal, one table read
//  at a time. A result is read only after the previous one is accepted. Reset clears
//  the point count; stores need no clearing.
//  s_tready is high only when idle; results stall cleanly on m_tready.
module tsp_two_opt_search #(
    parameter int MAX_POINTS = tsp2opt_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = tsp2opt_pkg::DEF_COORD_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata, // x_coord, y_coord
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [tsp2opt_pkg::OUT_W-1:0] m_tdata, // city_index, total_length
    output logic m_tlast
);

    import tsp2opt_pkg::*;

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DW     = COORD_BITS + 1;
    localparam int SUM_W  = DW + IDX_W;
    localparam int DT_DEP = 1 << (2 * IDX_W);
    localparam int ST_W   = 24;

    typedef enum logic [ST_W-1:0] {
        S_IDLE = ST_W'(1) << 0,
        L_RD   = ST_W'(1) << 1,
        L_CAP  = ST_W'(1) << 2,
        L_WAIT = ST_W'(1) << 3,
        L_WR2  = ST_W'(1) << 4,
        L_DIAG = ST_W'(1) << 5,
        S_INIT = ST_W'(1) << 6,
        B_RD   = ST_W'(1) << 7,
        B_ACC  = ST_W'(1) << 8,
        T_RA   = ST_W'(1) << 9,
        T_RB   = ST_W'(1) << 10,
        T_RC   = ST_W'(1) << 11,
        T_RD   = ST_W'(1) << 12,
        T_D0   = ST_W'(1) << 13,
        T_D1   = ST_W'(1) << 14,
        T_D2   = ST_W'(1) << 15,
        T_D3   = ST_W'(1) << 16,
        T_D4   = ST_W'(1) << 17,
        T_CMP  = ST_W'(1) << 18,
        R_RA   = ST_W'(1) << 19,
        R_RB   = ST_W'(1) << 20,
        R_WA   = ST_W'(1) << 21,
        R_WB   = ST_W'(1) << 22,
        O_RD   = ST_W'(1) << 23
    } seq_state_t;

    seq_state_t state_reg;
    logic       out_wait_reg;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] p_reg, k_reg, i_reg, j_reg, lo_reg, hi_reg;
    logic [IDX_W-1:0] ca_reg, cb_reg, cc_reg, cd_reg, ta_reg;
    logic             last_reg;
    logic signed [COORD_BITS-1:0] nx_reg, ny_reg;
    logic [DW-1:0]    dhold_reg;
    logic [SUM_W-1:0] acc_reg, old_reg, new_reg, best_reg;
    logic [IDX_W-1:0] city_reg;

    logic [CNT_W-1:0] kp1, jp1, ip2, lop2;
    logic [IDX_W-1:0] kn, jn;
    logic             accept;

    // point store
    logic                    pt_we;
    logic [2*COORD_BITS-1:0] pt_rdata;
    // distance table
    logic                  dt_we;
    logic [2*IDX_W-1:0]    dt_waddr, dt_raddr;
    logic [DW-1:0]         dt_wdata, dt_rdata;
    // tour
    logic             tr_we;
    logic [IDX_W-1:0] tr_waddr, tr_wdata, tr_raddr, tr_rdata;
    // distance unit
    logic          dist_start, dist_done;
    logic [DW-1:0] dist_val;

    // output register loads from the tour read in the cycle after O_RD
    logic load_out_reg;
    logic olast_reg;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !out_wait_reg;

    assign kp1  = CNT_W'(k_reg) + CNT_W'(1);
    assign jp1  = CNT_W'(j_reg) + CNT_W'(1);
    assign ip2  = CNT_W'(i_reg) + CNT_W'(2);
    assign lop2 = CNT_W'(lo_reg) + CNT_W'(2);
    assign kn   = (kp1 == count_reg) ? '0 : IDX_W'(kp1);
    assign jn   = (jp1 == count_reg) ? '0 : IDX_W'(jp1);

    assign pt_we = accept && (count_reg < CNT_W'(MAX_POINTS));
    assign dist_start = (state_reg == L_CAP);

    tsp2opt_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (IDX_W'(count_reg)),
        .wdata (s_tdata[2*COORD_BITS-1:0]),
        .raddr (k_reg),
        .rdata (pt_rdata)
    );

    tsp2opt_ram #(.WIDTH(DW), .DEPTH(DT_DEP)) u_dt_ram (
        .clk   (clk),
        .we    (dt_we),
        .waddr (dt_waddr),
        .wdata (dt_wdata),
        .raddr (dt_raddr),
        .rdata (dt_rdata)
    );

    tsp2opt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_tour_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    tsp2opt_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dist_start),
        .x1       (pt_rdata[COORD_BITS-1:0]),
        .y1       (pt_rdata[2*COORD_BITS-1:COORD_BITS]),
        .x2       (nx_reg),
        .y2       (ny_reg),
        .done     (dist_done),
        .dist_out (dist_val)
    );

    // memory port steering
    always_comb
    begin
        dt_we    = 1'b0;
        dt_waddr = {k_reg, p_reg};
        dt_wdata = dist_val;
        dt_raddr = {k_reg, kn};
        tr_we    = 1'b0;
        tr_waddr = k_reg;
        tr_wdata = k_reg;
        tr_raddr = k_reg;
        case (state_reg)
            L_WAIT: dt_we = dist_done;
            L_WR2:
            begin
                dt_we    = 1'b1;
                dt_waddr = {p_reg, k_reg};
                dt_wdata = dhold_reg;
            end
            L_DIAG:
            begin
                dt_we    = 1'b1;
                dt_waddr = {p_reg, p_reg};
                dt_wdata = '0;
            end
            S_INIT: tr_we = 1'b1;
            T_RA: tr_raddr = i_reg - IDX_W'(1);
            T_RB: tr_raddr = i_reg;
            T_RC: tr_raddr = j_reg;
            T_RD: tr_raddr = jn;
            T_D0: dt_raddr = {ca_reg, cb_reg};
            T_D1: dt_raddr = {cc_reg, cd_reg};
            T_D2: dt_raddr = {ca_reg, cc_reg};
            T_D3: dt_raddr = {cb_reg, cd_reg};
            R_RA: tr_raddr = lo_reg;
            R_RB: tr_raddr = hi_reg;
            R_WA:
            begin
                tr_we    = 1'b1;
                tr_waddr = lo_reg;
                tr_wdata = tr_rdata;
            end
            R_WB:
            begin
                tr_we    = 1'b1;
                tr_waddr = hi_reg;
                tr_wdata = ta_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_wait_reg <= 1'b0;
            count_reg    <= '0;
            best_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_wait_reg)
                    begin
                        // advance only on an accepted result
                        if (m_tready && !load_out_reg)
                        begin
                            out_wait_reg <= 1'b0;
                            if (m_tlast)
                            begin
                                count_reg <= '0;
                            end
                            else
                            begin
                                k_reg     <= IDX_W'(kp1);
                                state_reg <= O_RD;
                            end
                        end
                    end
                    else if (accept)
                    begin
                        last_reg <= s_tlast;
                        k_reg    <= '0;
                        if (pt_we)
                        begin
                            p_reg  <= IDX_W'(count_reg);
                            nx_reg <= s_tdata[COORD_BITS-1:0];
                            ny_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
                            state_reg <= (count_reg == '0) ? L_DIAG : L_RD;
                        end
                        else if (s_tlast)
                        begin
                            // full set: drop the point, still run the search
                            state_reg <= S_INIT;
                        end
                    end
                end
                L_RD:   state_reg <= L_CAP;
                L_CAP:  state_reg <= L_WAIT;
                L_WAIT:
                begin
                    if (dist_done)
                    begin
                        dhold_reg <= dist_val;
                        state_reg <= L_WR2;
                    end
                end
                L_WR2:
                begin
                    k_reg     <= IDX_W'(kp1);
                    state_reg <= (kp1 == CNT_W'(p_reg)) ? L_DIAG : L_RD;
                end
                L_DIAG:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    k_reg     <= '0;
                    state_reg <= last_reg ? S_INIT : S_IDLE;
                end
                S_INIT:
                begin
                    acc_reg <= '0;
                    if (kp1 == count_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= B_RD;
                    end
                    else
                    begin
                        k_reg <= IDX_W'(kp1);
                    end
                end
                B_RD: state_reg <= B_ACC;
                B_ACC:
                begin
                    acc_reg <= acc_reg + SUM_W'(dt_rdata);
                    if (kp1 == count_reg)
                    begin
                        best_reg  <= acc_reg + SUM_W'(dt_rdata);
                        i_reg     <= IDX_W'(1);
                        j_reg     <= IDX_W'(2);
                        k_reg     <= '0;
                        state_reg <= (count_reg < CNT_W'(3)) ? O_RD : T_RA;
                    end
                    else
                    begin
                        k_reg     <= IDX_W'(kp1);
                        state_reg <= B_RD;
                    end
                end
                T_RA: state_reg <= T_RB;
                T_RB:
                begin
                    ca_reg    <= tr_rdata;
                    state_reg <= T_RC;
                end
                T_RC:
                begin
                    cb_reg    <= tr_rdata;
                    state_reg <= T_RD;
                end
                T_RD:
                begin
                    cc_reg    <= tr_rdata;
                    state_reg <= T_D0;
                end
                T_D0:
                begin
                    cd_reg    <= tr_rdata;
                    state_reg <= T_D1;
                end
                T_D1:
                begin
                    old_reg   <= SUM_W'(dt_rdata);
                    state_reg <= T_D2;
                end
                T_D2:
                begin
                    old_reg   <= old_reg + SUM_W'(dt_rdata);
                    state_reg <= T_D3;
                end
                T_D3:
                begin
                    new_reg   <= SUM_W'(dt_rdata);
                    state_reg <= T_D4;
                end
                T_D4:
                begin
                    new_reg   <= new_reg + SUM_W'(dt_rdata);
                    state_reg <= T_CMP;
                end
                T_CMP:
                begin
                    // only the edge at each end of the segment changes
                    if (new_reg < old_reg)
                    begin
                        best_reg  <= best_reg + new_reg - old_reg;
                        lo_reg    <= i_reg;
                        hi_reg    <= j_reg;
                        state_reg <= R_RA;
                    end
                    else if (jp1 != count_reg)
                    begin
                        j_reg     <= IDX_W'(jp1);
                        state_reg <= T_RA;
                    end
                    else if (ip2 < count_reg)
                    begin
                        i_reg     <= IDX_W'(CNT_W'(i_reg) + CNT_W'(1));
                        j_reg     <= IDX_W'(ip2);
                        state_reg <= T_RA;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= O_RD;
                    end
                end
                R_RA: state_reg <= R_RB;
                R_RB:
                begin
                    ta_reg    <= tr_rdata;
                    state_reg <= R_WA;
                end
                R_WA: state_reg <= R_WB;
                R_WB:
                begin
                    lo_reg <= lo_reg + IDX_W'(1);
                    hi_reg <= hi_reg - IDX_W'(1);
                    if (lop2 < CNT_W'(hi_reg))
                    begin
                        state_reg <= R_RA;
                    end
                    else
                    begin
                        // restart the scan on the improved tour
                        i_reg     <= IDX_W'(1);
                        j_reg     <= IDX_W'(2);
                        state_reg <= T_RA;
                    end
                end
                O_RD:
                begin
                    out_wait_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_out_reg <= 1'b0;
        end
        else
        begin
            load_out_reg <= (state_reg == O_RD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == O_RD)
        begin
            olast_reg <= (kp1 == count_reg);
        end
        if (load_out_reg)
        begin
            city_reg <= tr_rdata;
        end
    end

    assign m_tvalid = out_wait_reg && !load_out_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {(OUT_W - CITY_W - LEN_W)'(0), LEN_W'(best_reg), CITY_W'(city_reg)};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_dist_done: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == L_WAIT))
        else $error("distance result outside the load wait");

    a_scan_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CMP) |-> (count_reg >= CNT_W'(3)) && (i_reg < j_reg))
        else $error("2-opt trial on an invalid segment");

    a_best_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == R_RA) && $past(state_reg == T_CMP) |-> (best_reg < $past(best_reg)))
        else $error("accepted trial did not shorten the tour");

endmodule

// File: tb/tsp_two_opt_search_tb.sv
// Self-checking testbench for the 2-opt tour search block: point sets in, tours out.
module tsp_two_opt_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsp2opt_pkg::*;

    localparam int NPTS     = DEF_MAX_POINTS;
    localparam int CBITS    = DEF_COORD_BITS;
    localparam int SW       = ((2 * CBITS + 7) / 8) * 8;
    localparam int STALL_MAX = 2000000;
    localparam longint CMAX = (1 << (CBITS - 1)) - 1;
    localparam longint CMIN = -(1 << (CBITS - 1));

    typedef struct packed {
        logic [CITY_W-1:0] city;
        logic [LEN_W-1:0]  length;
        logic              last;
    } stop_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tlast;

    // predictor state
    longint px[NPTS];
    longint py[NPTS];
    longint unsigned dmat[NPTS][NPTS];
    int unsigned tour[NPTS];
    int unsigned trial[NPTS];
    int loaded = 0;
    stop_t tour_stops[$];

    int errors = 0;
    int sent = 0;
    bit quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    tsp_two_opt_search u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint unsigned round_distance(longint x1, longint y1,
                                                        longint x2, longint y2);
        longint unsigned dx, dy, s, r, b;
        dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
        dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
        s = dx * dx + dy * dy;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        // s now holds the remainder; round half up
        if (s > r)
            r++;
        return r;
    endfunction

    function automatic longint unsigned trial_length(int n);
        longint unsigned sum;
        sum = dmat[trial[n-1]][trial[0]];
        for (int k = 0; k + 1 < n; k++)
            sum += dmat[trial[k]][trial[k+1]];
        return sum;
    endfunction

    // First-improvement 2-opt over the loaded set; queue one stop per tour position.
    function automatic void plan_tour(int n);
        longint unsigned best, len;
        bit hit;
        stop_t st;
        for (int k = 0; k < n; k++)
        begin
            tour[k] = k;
            trial[k] = k;
        end
        best = trial_length(n);
        do
        begin
            hit = 1'b0;
            for (int i = 1; i + 1 < n && !hit; i++)
                for (int j = i + 1; j < n && !hit; j++)
                begin
                    for (int k = 0; k < n; k++)
                        trial[k] = (k >= i && k <= j) ? tour[i + j - k] : tour[k];
                    len = trial_length(n);
                    if (len < best)
                    begin
                        best = len;
                        for (int k = 0; k < n; k++)
                            tour[k] = trial[k];
                        hit = 1'b1;
                    end
                end
        end
        while (hit);
        for (int k = 0; k < n; k++)
        begin
            st.city = tour[k][CITY_W-1:0];
            st.length = best[LEN_W-1:0];
            st.last = (k + 1 == n);
            tour_stops.push_back(st);
        end
    endfunction

    function automatic void load_point(longint x, longint y, bit last);
        int p;
        if (loaded < NPTS)
        begin
            p = loaded;
            px[p] = x;
            py[p] = y;
            for (int k = 0; k < p; k++)
            begin
                dmat[k][p] = round_distance(px[k], py[k], x, y);
                dmat[p][k] = dmat[k][p];
            end
            dmat[p][p] = 0;
            loaded = p + 1;
        end
        if (last)
        begin
            plan_tour(loaded);
            loaded = 0;
        end
    endfunction

    // Send one point request; valid stays high across back-to-back requests.
    task automatic send_point(longint x, longint y, bit last);
        int gap;
        logic [CBITS-1:0] xb, yb;
        gap = rand_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        xb = x[CBITS-1:0];
        yb = y[CBITS-1:0];
        s_tvalid <= 1'b1;
        s_tdata <= SW'({yb, xb});
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        load_point(x, y, last);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (tour_stops.size() == 0);
        @(posedge clk);
    endtask

    task automatic send_random_set(int n, int mode);
        longint x, y;
        for (int k = 0; k < n; k++)
        begin
            case (mode)
                0: begin
                    x = $signed(CBITS'($urandom));
                    y = $signed(CBITS'($urandom));
                end
                1: begin
                    x = longint'($urandom_range(0, 16)) - 8;
                    y = longint'($urandom_range(0, 16)) - 8;
                end
                default: begin
                    x = $urandom_range(0, 1) ? CMAX : CMIN;
                    y = $urandom_range(0, 1) ? CMAX : CMIN;
                end
            endcase
            send_point(x, y, k == n - 1);
        end
    endtask

    task automatic test_extremes();
        send_point(CMIN, CMIN, 1'b0);
        send_point(CMAX, CMAX, 1'b1);
        send_point(CMIN, CMAX, 1'b0);
        send_point(CMAX, CMIN, 1'b0);
        send_point(CMAX, CMAX, 1'b0);
        send_point(CMIN, CMIN, 1'b1);
        // single city
        send_point(-1, 1, 1'b1);
        // duplicates give zero distances
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b1);
    endtask

    task automatic test_crossing();
        // crossed square: the search must uncross it
        drain();
        send_point(0, 0, 1'b0);
        send_point(10, 10, 1'b0);
        send_point(10, 0, 1'b0);
        send_point(0, 10, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(300, 400, 1'b0);
        send_point(300, 0, 1'b0);
        send_point(0, 400, 1'b0);
        send_point(150, 200, 1'b1);
    endtask

    task automatic test_overflow();
        // collinear points in load order are already optimal, keeping the search short
        drain();
        for (int k = 0; k < NPTS + 2; k++)
            send_point(CMIN + k * 16000, 3 - k, k == NPTS + 1);
        send_random_set(14, 0);
    endtask

    task automatic test_random();
        int n, r;
        while (sent < 370)
        begin
            r = $urandom_range(0, 99);
            n = (r < 5) ? 1 : (r < 85) ? $urandom_range(2, 8) : $urandom_range(9, 14);
            if ($urandom_range(0, 9) == 0)
                drain();
            if ($urandom_range(0, 7) == 0)
                quiet = ~quiet;
            r = $urandom_range(0, 9);
            send_random_set(n, (r < 6) ? 0 : (r < 9) ? 1 : 2);
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(1, 3);
        end
    end

    // compare each result against the oldest expected stop
    always @(posedge clk)
    begin
        stop_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tour_stops.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual city %0d len %0d",
                         $time, m_tdata[CITY_W-1:0], m_tdata[CITY_W+LEN_W-1:CITY_W]);
                errors++;
            end
            else
            begin
                want = tour_stops.pop_front();
                if (m_tdata[CITY_W-1:0] !== want.city)
                begin
                    $display("%0t city_index: expected %0d actual %0d",
                             $time, want.city, m_tdata[CITY_W-1:0]);
                    errors++;
                end
                if (m_tdata[CITY_W+LEN_W-1:CITY_W] !== want.length)
                begin
                    $display("%0t total_length: expected %0d actual %0d",
                             $time, want.length, m_tdata[CITY_W+LEN_W-1:CITY_W]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t last_city: expected %0b actual %0b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_crossing();
        test_overflow();
        test_random();
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && tour_stops.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
